### design/ptsws_pkg.sv
// Shared types and constants of the process table sleep/wakeup scheduler.
`timescale 1ns / 1ps

package ptsws_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths fixed by the stream format
    localparam int REQ_W   = 3;
    localparam int PIDX_W  = 6;
    localparam int CH_W    = 16;
    localparam int PRI_W   = 8;
    localparam int SFLAG_W = 2;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int ID_W    = 16;
    localparam int WAKE_W  = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SLEEP   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WAKEUP  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PICK    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOADED  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd5;

    // Entry status codes
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_SLEEP = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] RES_OK   = 2'd0;
    localparam logic [STAT_W-1:0] RES_IDLE = 2'd1;
    localparam logic [STAT_W-1:0] RES_FULL = 2'd2;

    // Swapper flag codes carried by a sleep request
    localparam logic [SFLAG_W-1:0] SWF_IN  = 2'd1;
    localparam logic [SFLAG_W-1:0] SWF_OUT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SWAPIN  = 1'b0;
    localparam logic CFG_SWAPOUT = 1'b1;

    // Pick only takes priorities below this limit
    localparam logic signed [PRI_W-1:0] PRI_LIMIT = 8'sd127;

    // Reset values of the channel registers
    localparam logic [CH_W-1:0] SWAPIN_RESET  = 16'd1;
    localparam logic [CH_W-1:0] SWAPOUT_RESET = 16'd2;

    // One process table entry as stored in the memory
    typedef struct packed {
        logic [1:0]             status;
        logic [CH_W-1:0]        channel;
        logic signed [PRI_W-1:0] prio;
        logic                   loaded;
    } entry_t;

endpackage

### design/process_table_sleep_wake_scheduler.sv
// Top level of the process table sleep/wakeup scheduler.
`timescale 1ns / 1ps

// The process table lives in one 64-entry synchronous memory (registered read
// port, one read and one write per cycle); a single sequencer reads,
// modifies and writes entries back. Requests are taken one at a time. Release
// and unknown requests go straight to the result; sleep and set loaded first
// read the addressed entry. Pick and create stream through the table at one
// entry per cycle and then drain the read pipeline (create stops at the first
// empty entry). Wakeup streams through the table the same way, with a second
// pass for the swap-out channel; a sleep that wakes the swap-in channel runs
// the wakeup passes after it.
// A new request is taken while the previous result still waits on the output.
// Entries never written since reset read as empty through per-entry valid
// bits, so no clearing pass is needed after reset.
module process_table_sleep_wake_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [ptsws_pkg::CH_W-1:0]        cfg_wdata,
    // Request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // proc_index[5:0], channel[21:6], priority_req[29:22], loaded[30],
    // swapper_flag[32:31], zero fill[39:33]
    input  logic [ptsws_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type[2:0]
    input  logic [ptsws_pkg::REQ_W-1:0]       s_axis_tuser,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // slot_index[5:0], new_id[21:6], wake_count[28:22], reschedule[29],
    // zero fill[31:30]
    output logic [ptsws_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [ptsws_pkg::STAT_W-1:0]      m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLEEP,
        S_LOADED,
        S_WAKE,
        S_PICK,
        S_CREATE,
        S_DONE
    } state_t;

    // Table memory and its registered read port
    ptsws_pkg::entry_t entry_mem [ptsws_pkg::TABLE_ENTRIES];
    ptsws_pkg::entry_t rd_data_reg;
    logic              rd_valid_reg;
    logic [ptsws_pkg::TABLE_ENTRIES-1:0] entry_valid_reg;

    logic                         mem_we;
    logic [ptsws_pkg::IDX_W-1:0]  mem_waddr;
    ptsws_pkg::entry_t            mem_wdata;
    logic                         mem_re;
    logic [ptsws_pkg::IDX_W-1:0]  mem_raddr;
    ptsws_pkg::entry_t            rd_entry;

    // Sequencer registers
    state_t                         state_reg, state_next;
    logic [ptsws_pkg::IDX_W-1:0]    scan_addr_reg, scan_addr_next;
    logic [ptsws_pkg::CNT_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                           pend_reg, pend_next;
    logic [ptsws_pkg::IDX_W-1:0]    pend_addr_reg, pend_addr_next;
    logic [ptsws_pkg::CH_W-1:0]     wake_ch_reg, wake_ch_next;
    logic signed [ptsws_pkg::PRI_W-1:0] pri_reg, pri_next;
    logic [ptsws_pkg::SFLAG_W-1:0]  sflag_reg, sflag_next;
    logic                           ld_reg, ld_next;
    logic                           again_reg, again_next;
    logic signed [ptsws_pkg::PRI_W-1:0] best_reg, best_next;
    logic                           found_reg, found_next;
    logic [ptsws_pkg::CNT_W-1:0]    wake_cnt_reg, wake_cnt_next;
    logic [ptsws_pkg::STAT_W-1:0]   res_status_reg, res_status_next;
    logic [ptsws_pkg::IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic [ptsws_pkg::ID_W-1:0]     res_id_reg, res_id_next;

    // Architectural state outside the table
    logic [ptsws_pkg::IDX_W-1:0]    last_chosen_reg, last_chosen_next;
    logic [ptsws_pkg::ID_W-1:0]     last_id_reg, last_id_next;
    logic                           swapin_waiting_reg, swapin_waiting_next;
    logic                           swapout_waiting_reg, swapout_waiting_next;
    logic [ptsws_pkg::CH_W-1:0]     swapin_channel_reg, swapin_channel_next;
    logic [ptsws_pkg::CH_W-1:0]     swapout_channel_reg, swapout_channel_next;

    // Output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [ptsws_pkg::STAT_W-1:0]   out_status_reg, out_status_next;
    logic [ptsws_pkg::SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [ptsws_pkg::ID_W-1:0]     out_id_reg, out_id_next;
    logic [ptsws_pkg::WAKE_W-1:0]   out_wake_reg, out_wake_next;
    logic                           out_resched_reg, out_resched_next;

    // Unpacked request fields
    logic [ptsws_pkg::REQ_W-1:0]        in_req;
    logic [ptsws_pkg::PIDX_W-1:0]       in_idx;
    logic [ptsws_pkg::CH_W-1:0]         in_ch;
    logic signed [ptsws_pkg::PRI_W-1:0] in_pri;
    logic                               in_ld;
    logic [ptsws_pkg::SFLAG_W-1:0]      in_sflag;
    logic                               in_table;
    logic [ptsws_pkg::IDX_W-1:0]        in_addr;
    logic                               out_free;
    logic                               scan_more;
    logic                               swin;
    logic                               swout;

    // Next table index with wrap-around
    function automatic logic [ptsws_pkg::IDX_W-1:0] next_index(
        input logic [ptsws_pkg::IDX_W-1:0] a);
        logic [ptsws_pkg::IDX_W-1:0] n;
        if (a == ptsws_pkg::IDX_W'(ptsws_pkg::TABLE_ENTRIES - 1)) begin
            n = '0;
        end
        else begin
            n = ptsws_pkg::IDX_W'(a + 1'b1);
        end
        return n;
    endfunction

    assign in_req   = s_axis_tuser;
    assign in_idx   = s_axis_tdata[5:0];
    assign in_ch    = s_axis_tdata[21:6];
    assign in_pri   = $signed(s_axis_tdata[29:22]);
    assign in_ld    = s_axis_tdata[30];
    assign in_sflag = s_axis_tdata[32:31];
    assign in_table = (32'(in_idx) < ptsws_pkg::TABLE_ENTRIES);
    assign in_addr  = ptsws_pkg::IDX_W'(in_idx);

    // Entries never written since reset read as empty and zero
    assign rd_entry  = rd_valid_reg ? rd_data_reg : '0;
    assign out_free  = !m_tvalid_reg || m_axis_tready;
    assign scan_more = (scan_cnt_reg != ptsws_pkg::CNT_W'(ptsws_pkg::TABLE_ENTRIES));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {2'b00, out_resched_reg, out_wake_reg, out_id_reg, out_slot_reg};

    // Sequencer next-state and memory access logic
    always_comb
    begin
        state_next           = state_reg;
        scan_addr_next       = scan_addr_reg;
        scan_cnt_next        = scan_cnt_reg;
        pend_next            = 1'b0;
        pend_addr_next       = pend_addr_reg;
        wake_ch_next         = wake_ch_reg;
        pri_next             = pri_reg;
        sflag_next           = sflag_reg;
        ld_next              = ld_reg;
        again_next           = again_reg;
        best_next            = best_reg;
        found_next           = found_reg;
        wake_cnt_next        = wake_cnt_reg;
        res_status_next      = res_status_reg;
        res_slot_next        = res_slot_reg;
        res_id_next          = res_id_reg;
        last_chosen_next     = last_chosen_reg;
        last_id_next         = last_id_reg;
        swapin_waiting_next  = swapin_waiting_reg;
        swapout_waiting_next = swapout_waiting_reg;
        swapin_channel_next  = swapin_channel_reg;
        swapout_channel_next = swapout_channel_reg;
        m_tvalid_next        = m_tvalid_reg;
        out_status_next      = out_status_reg;
        out_slot_next        = out_slot_reg;
        out_id_next          = out_id_reg;
        out_wake_next        = out_wake_reg;
        out_resched_next     = out_resched_reg;
        mem_we               = 1'b0;
        mem_waddr            = pend_addr_reg;
        mem_wdata            = rd_entry;
        mem_re               = 1'b0;
        mem_raddr            = scan_addr_reg;
        swin                 = swapin_waiting_reg | (sflag_reg == ptsws_pkg::SWF_IN);
        swout                = swapout_waiting_reg | (sflag_reg == ptsws_pkg::SWF_OUT);

        // Configuration writes
        if (cfg_we) begin
            unique case (cfg_index)
                ptsws_pkg::CFG_SWAPIN:  swapin_channel_next  = cfg_wdata;
                ptsws_pkg::CFG_SWAPOUT: swapout_channel_next = cfg_wdata;
                default: ;
            endcase
        end

        // Result taken downstream
        if (m_tvalid_reg && m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid) begin
                    res_status_next = ptsws_pkg::RES_OK;
                    res_slot_next   = '0;
                    res_id_next     = '0;
                    wake_cnt_next   = '0;
                    again_next      = 1'b0;
                    found_next      = 1'b0;
                    best_next       = ptsws_pkg::PRI_LIMIT;
                    scan_cnt_next   = '0;
                    scan_addr_next  = '0;
                    pend_addr_next  = in_addr;
                    wake_ch_next    = in_ch;
                    pri_next        = in_pri;
                    sflag_next      = in_sflag;
                    ld_next         = in_ld;
                    state_next      = S_DONE;
                    unique case (in_req)
                        ptsws_pkg::REQ_SLEEP:
                        begin
                            if (in_table) begin
                                mem_re     = 1'b1;
                                mem_raddr  = in_addr;
                                state_next = S_SLEEP;
                            end
                        end
                        ptsws_pkg::REQ_WAKEUP:
                        begin
                            state_next = S_WAKE;
                        end
                        ptsws_pkg::REQ_PICK:
                        begin
                            scan_addr_next = next_index(last_chosen_reg);
                            state_next     = S_PICK;
                        end
                        ptsws_pkg::REQ_LOADED:
                        begin
                            if (in_table) begin
                                mem_re     = 1'b1;
                                mem_raddr  = in_addr;
                                state_next = S_LOADED;
                            end
                        end
                        ptsws_pkg::REQ_CREATE:
                        begin
                            state_next = S_CREATE;
                        end
                        ptsws_pkg::REQ_RELEASE:
                        begin
                            if (in_table) begin
                                mem_we    = 1'b1;
                                mem_waddr = in_addr;
                                mem_wdata = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Sleep: the entry read last cycle is rewritten unless it is empty, and may wake the swap-in channel
            S_SLEEP:
            begin
                state_next = S_DONE;
                if (rd_entry.status != ptsws_pkg::ST_EMPTY) begin
                    mem_we            = 1'b1;
                    mem_wdata.status  = pri_reg[ptsws_pkg::PRI_W-1] ? ptsws_pkg::ST_SLEEP
                                                                    : ptsws_pkg::ST_WAIT;
                    mem_wdata.channel = wake_ch_reg;
                    mem_wdata.prio    = pri_reg;
                    swapout_waiting_next = swout;
                    swapin_waiting_next  = swin;
                    if (!pri_reg[ptsws_pkg::PRI_W-1] && swin) begin
                        swapin_waiting_next = 1'b0;
                        wake_ch_next        = swapin_channel_reg;
                        state_next          = S_WAKE;
                    end
                end
            end

            // Set loaded: read-modify-write of the addressed entry
            S_LOADED:
            begin
                mem_we           = 1'b1;
                mem_wdata.loaded = ld_reg;
                state_next       = S_DONE;
            end

            // Wakeup pass: stream through the table, one entry per cycle
            S_WAKE:
            begin
                if (pend_reg && rd_entry.channel == wake_ch_reg) begin
                    mem_we            = 1'b1;
                    mem_wdata.status  = ptsws_pkg::ST_RUN;
                    mem_wdata.channel = '0;
                    wake_cnt_next     = ptsws_pkg::CNT_W'(wake_cnt_reg + 1'b1);
                    if (swapout_waiting_reg && !rd_entry.loaded) begin
                        swapout_waiting_next = 1'b0;
                        again_next           = 1'b1;
                    end
                end
                if (wake_ch_reg != '0 && scan_more) begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = scan_addr_reg;
                    scan_addr_next = next_index(scan_addr_reg);
                    scan_cnt_next  = ptsws_pkg::CNT_W'(scan_cnt_reg + 1'b1);
                end
                else if (!pend_reg) begin
                    if (again_reg) begin
                        // Second pass on the swap-out channel
                        again_next     = 1'b0;
                        wake_ch_next   = swapout_channel_reg;
                        scan_addr_next = '0;
                        scan_cnt_next  = '0;
                    end
                    else begin
                        state_next = S_DONE;
                    end
                end
            end

            // Pick: round-robin scan for the lowest priority runnable, loaded entry
            S_PICK:
            begin
                if (pend_reg && rd_entry.status == ptsws_pkg::ST_RUN && rd_entry.loaded
                    && rd_entry.prio < best_reg) begin
                    best_next     = rd_entry.prio;
                    res_slot_next = pend_addr_reg;
                    found_next    = 1'b1;
                end
                if (scan_more) begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = scan_addr_reg;
                    scan_addr_next = next_index(scan_addr_reg);
                    scan_cnt_next  = ptsws_pkg::CNT_W'(scan_cnt_reg + 1'b1);
                end
                else if (!pend_reg) begin
                    if (found_reg) begin
                        last_chosen_next = res_slot_reg;
                    end
                    else begin
                        res_status_next = ptsws_pkg::RES_IDLE;
                    end
                    state_next = S_DONE;
                end
            end

            // Create: claim the first empty entry
            S_CREATE:
            begin
                priority if (pend_reg && rd_entry.status == ptsws_pkg::ST_EMPTY) begin
                    mem_we           = 1'b1;
                    mem_wdata.status = ptsws_pkg::ST_RUN;
                    mem_wdata.channel = '0;
                    mem_wdata.prio   = '0;
                    mem_wdata.loaded = 1'b1;
                    last_id_next     = ptsws_pkg::ID_W'(last_id_reg + 1'b1);
                    res_id_next      = ptsws_pkg::ID_W'(last_id_reg + 1'b1);
                    res_slot_next    = pend_addr_reg;
                    state_next       = S_DONE;
                end
                else if (scan_more) begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = scan_addr_reg;
                    scan_addr_next = next_index(scan_addr_reg);
                    scan_cnt_next  = ptsws_pkg::CNT_W'(scan_cnt_reg + 1'b1);
                end
                else if (!pend_reg) begin
                    res_status_next = ptsws_pkg::RES_FULL;
                    state_next      = S_DONE;
                end
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (out_free) begin
                    m_tvalid_next    = 1'b1;
                    out_status_next  = res_status_reg;
                    out_slot_next    = ptsws_pkg::SLOT_W'(res_slot_reg);
                    out_id_next      = res_id_reg;
                    out_wake_next    = ptsws_pkg::WAKE_W'(wake_cnt_reg);
                    out_resched_next = (wake_cnt_reg != '0);
                    state_next       = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= entry_mem[mem_raddr];
        end
    end

    // Control state, valid bits and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg           <= S_IDLE;
            entry_valid_reg     <= '0;
            rd_valid_reg        <= 1'b0;
            scan_addr_reg       <= '0;
            scan_cnt_reg        <= '0;
            pend_reg            <= 1'b0;
            pend_addr_reg       <= '0;
            wake_ch_reg         <= '0;
            pri_reg             <= '0;
            sflag_reg           <= '0;
            ld_reg              <= 1'b0;
            again_reg           <= 1'b0;
            best_reg            <= ptsws_pkg::PRI_LIMIT;
            found_reg           <= 1'b0;
            wake_cnt_reg        <= '0;
            res_status_reg      <= ptsws_pkg::RES_OK;
            res_slot_reg        <= '0;
            res_id_reg          <= '0;
            last_chosen_reg     <= '0;
            last_id_reg         <= '0;
            swapin_waiting_reg  <= 1'b0;
            swapout_waiting_reg <= 1'b0;
            swapin_channel_reg  <= ptsws_pkg::SWAPIN_RESET;
            swapout_channel_reg <= ptsws_pkg::SWAPOUT_RESET;
            m_tvalid_reg        <= 1'b0;
            out_status_reg      <= ptsws_pkg::RES_OK;
            out_slot_reg        <= '0;
            out_id_reg          <= '0;
            out_wake_reg        <= '0;
            out_resched_reg     <= 1'b0;
        end
        else begin
            if (mem_we) begin
                entry_valid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re) begin
                rd_valid_reg <= entry_valid_reg[mem_raddr];
            end
            state_reg           <= state_next;
            scan_addr_reg       <= scan_addr_next;
            scan_cnt_reg        <= scan_cnt_next;
            pend_reg            <= pend_next;
            pend_addr_reg       <= pend_addr_next;
            wake_ch_reg         <= wake_ch_next;
            pri_reg             <= pri_next;
            sflag_reg           <= sflag_next;
            ld_reg              <= ld_next;
            again_reg           <= again_next;
            best_reg            <= best_next;
            found_reg           <= found_next;
            wake_cnt_reg        <= wake_cnt_next;
            res_status_reg      <= res_status_next;
            res_slot_reg        <= res_slot_next;
            res_id_reg          <= res_id_next;
            last_chosen_reg     <= last_chosen_next;
            last_id_reg         <= last_id_next;
            swapin_waiting_reg  <= swapin_waiting_next;
            swapout_waiting_reg <= swapout_waiting_next;
            swapin_channel_reg  <= swapin_channel_next;
            swapout_channel_reg <= swapout_channel_next;
            m_tvalid_reg        <= m_tvalid_next;
            out_status_reg      <= out_status_next;
            out_slot_reg        <= out_slot_next;
            out_id_reg          <= out_id_next;
            out_wake_reg        <= out_wake_next;
            out_resched_reg     <= out_resched_next;
        end
    end

endmodule
